@@ design/heading_pid_steering_unit_assert.svh @@
// Assertion macros used by the steering unit checker.
`ifndef HEADING_PID_STEERING_UNIT_ASSERT_SVH
`define HEADING_PID_STEERING_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define HPS_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("steering unit check failed");

// Next-cycle implication, disabled while reset is high.
`define HPS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("steering unit check failed");

`endif

@@ design/hps_pkg.sv @@
// Shared constants, types and the arctangent table of the steering unit.
package hps_pkg;

   localparam int COORD_BITS   = 24;
   localparam int CORDIC_STEPS = 16;
   localparam int ANGLE_W      = 16;
   localparam int GAIN_W       = 16;
   localparam int LIMIT_W      = 15;
   localparam int CSR_W        = 16;
   localparam int CSR_IDX_W    = 2;
   localparam int FRAC_BITS    = 12;

   // Vector width: difference, quarter-turn pre-rotation and CORDIC growth.
   localparam int CW           = COORD_BITS + 4;
   localparam int STEP_W       = $clog2(CORDIC_STEPS);
   localparam int ATAN_ENTRIES = 24;
   localparam int ATAN_IDX_W   = $clog2(ATAN_ENTRIES);

   localparam int DIFF_W       = ANGLE_W + 2;
   localparam int PROD_W       = DIFF_W + GAIN_W + 1;
   localparam int ACC_W        = PROD_W + 2;

   localparam logic [ANGLE_W-1:0] QUARTER_TURN     = 16'd16384;
   localparam logic [ANGLE_W-1:0] NEG_QUARTER_TURN = 16'd49152;
   localparam logic [GAIN_W-1:0]  KP_RESET         = 16'd1638;
   localparam logic [LIMIT_W-1:0] LIMIT_RESET      = 15'd5461;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CORDIC,
      ST_ERROR,
      ST_MUL_P,
      ST_MUL_I,
      ST_MUL_D,
      ST_ACC,
      ST_DONE
   } state_type;

   typedef enum logic [1:0] {
      MUL_P,
      MUL_I,
      MUL_D
   } mul_sel_type;

   typedef enum logic [1:0] {
      ACC_HOLD,
      ACC_LOAD,
      ACC_ADD
   } acc_op_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_KP    = 2'd0,
      CSR_KI    = 2'd1,
      CSR_KD    = 2'd2,
      CSR_LIMIT = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic        load;
      logic        step;
      logic        err;
      mul_sel_type mul_sel;
      acc_op_type  acc_op;
      logic        fin;
   } ctrl_cmd_type;

   typedef struct packed {
      logic cordic_last;
   } dp_status_type;

   // atan(2^-i) in binary-angle units, rounded to nearest.
   function automatic logic [ANGLE_W-1:0] atan_lookup(input logic [ATAN_IDX_W-1:0] idx);
      case (idx)
         5'd0:    atan_lookup = 16'd8192;
         5'd1:    atan_lookup = 16'd4836;
         5'd2:    atan_lookup = 16'd2555;
         5'd3:    atan_lookup = 16'd1297;
         5'd4:    atan_lookup = 16'd651;
         5'd5:    atan_lookup = 16'd326;
         5'd6:    atan_lookup = 16'd163;
         5'd7:    atan_lookup = 16'd81;
         5'd8:    atan_lookup = 16'd41;
         5'd9:    atan_lookup = 16'd20;
         5'd10:   atan_lookup = 16'd10;
         5'd11:   atan_lookup = 16'd5;
         5'd12:   atan_lookup = 16'd3;
         5'd13:   atan_lookup = 16'd1;
         5'd14:   atan_lookup = 16'd1;
         default: atan_lookup = 16'd0;
      endcase
   endfunction

endpackage

@@ design/hps_datapath.sv @@
// Datapath: gain registers, CORDIC vectoring unit, error history and PID multiply-accumulate.
module hps_datapath (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic signed [hps_pkg::COORD_BITS-1:0] req_target_x,
   input  logic signed [hps_pkg::COORD_BITS-1:0] req_target_y,
   input  logic signed [hps_pkg::COORD_BITS-1:0] req_position_x,
   input  logic signed [hps_pkg::COORD_BITS-1:0] req_position_y,
   input  logic signed [hps_pkg::ANGLE_W-1:0]    req_heading,
   input  logic                                  csr_wr_en,
   input  logic [hps_pkg::CSR_IDX_W-1:0]         csr_index,
   input  logic [hps_pkg::CSR_W-1:0]             csr_wdata,
   input  hps_pkg::ctrl_cmd_type                 cmd,
   output hps_pkg::dp_status_type                status,
   output logic signed [hps_pkg::ANGLE_W-1:0]    rsp_steer_increment,
   output logic                                  rsp_clamped
);

   // configuration
   logic [hps_pkg::GAIN_W-1:0]  kp_ff, ki_ff, kd_ff;
   logic [hps_pkg::LIMIT_W-1:0] limit_ff;

   // CORDIC
   logic signed [hps_pkg::CW-1:0] tx_e, ty_e, px_e, py_e;
   logic signed [hps_pkg::CW-1:0] dx, dy, ndx, ndy;
   logic signed [hps_pkg::CW-1:0] x_ff, y_ff, x_in, y_in;
   logic signed [hps_pkg::CW-1:0] xs, ys;
   logic [hps_pkg::ANGLE_W-1:0]   z_ff, z_in, atan_val;
   logic [hps_pkg::STEP_W-1:0]    cnt_ff, cnt_in;
   logic                          zero_ff, zero_in;
   logic [hps_pkg::ANGLE_W-1:0]   heading_ff, heading_in;

   // error history and differences
   logic [hps_pkg::ANGLE_W-1:0]       bearing;
   logic signed [hps_pkg::ANGLE_W-1:0] e0;
   logic signed [hps_pkg::ANGLE_W-1:0] e0_ff, e0_in, last_ff, last_in, prior_ff, prior_in;
   logic signed [hps_pkg::DIFF_W-1:0]  d1_ff, d1_in, d2_ff, d2_in;

   // multiply-accumulate
   logic signed [hps_pkg::GAIN_W:0]   mul_a;
   logic signed [hps_pkg::DIFF_W-1:0] mul_b;
   logic signed [hps_pkg::PROD_W-1:0] prod_ff, prod_in;
   logic signed [hps_pkg::ACC_W-1:0]  acc_ff, acc_in;

   // clamp
   logic signed [hps_pkg::ACC_W-1:0]   shifted, lim_pos, lim_neg, sat;
   logic                               clip;
   logic signed [hps_pkg::ANGLE_W-1:0] steer_ff, steer_in;
   logic                               clamped_ff, clamped_in;

   // ---------------- configuration registers ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         kp_ff    <= hps_pkg::KP_RESET;
         ki_ff    <= '0;
         kd_ff    <= '0;
         limit_ff <= hps_pkg::LIMIT_RESET;
      end else if (csr_wr_en) begin
         case (hps_pkg::csr_index_type'(csr_index))
            hps_pkg::CSR_KP:    kp_ff    <= csr_wdata;
            hps_pkg::CSR_KI:    ki_ff    <= csr_wdata;
            hps_pkg::CSR_KD:    kd_ff    <= csr_wdata;
            hps_pkg::CSR_LIMIT: limit_ff <= csr_wdata[hps_pkg::LIMIT_W-1:0];
            default: ;
         endcase
      end
   end

   // ---------------- CORDIC ----------------
   assign tx_e = hps_pkg::CW'(req_target_x);
   assign ty_e = hps_pkg::CW'(req_target_y);
   assign px_e = hps_pkg::CW'(req_position_x);
   assign py_e = hps_pkg::CW'(req_position_y);
   assign dx   = tx_e - px_e;
   assign dy   = ty_e - py_e;
   assign ndx  = px_e - tx_e;
   assign ndy  = py_e - ty_e;

   assign xs       = x_ff >>> cnt_ff;
   assign ys       = y_ff >>> cnt_ff;
   assign atan_val = hps_pkg::atan_lookup(hps_pkg::ATAN_IDX_W'(cnt_ff));

   assign status.cordic_last = (cnt_ff == hps_pkg::STEP_W'(hps_pkg::CORDIC_STEPS - 1));

   always_comb begin
      x_in       = x_ff;
      y_in       = y_ff;
      z_in       = z_ff;
      cnt_in     = cnt_ff;
      zero_in    = zero_ff;
      heading_in = heading_ff;
      if (cmd.load) begin
         // rotate left half plane vectors by a quarter turn
         if (dx < 0) begin
            if (dy >= 0) begin
               x_in = dy;
               y_in = ndx;
               z_in = hps_pkg::QUARTER_TURN;
            end else begin
               x_in = ndy;
               y_in = dx;
               z_in = hps_pkg::NEG_QUARTER_TURN;
            end
         end else begin
            x_in = dx;
            y_in = dy;
            z_in = '0;
         end
         cnt_in     = '0;
         zero_in    = (dx == 0) && (dy == 0);
         heading_in = req_heading;
      end else if (cmd.step) begin
         if (!y_ff[hps_pkg::CW-1]) begin
            x_in = x_ff + ys;
            y_in = y_ff - xs;
            z_in = z_ff + atan_val;
         end else begin
            x_in = x_ff - ys;
            y_in = y_ff + xs;
            z_in = z_ff - atan_val;
         end
         cnt_in = cnt_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      x_ff       <= x_in;
      y_ff       <= y_in;
      z_ff       <= z_in;
      cnt_ff     <= cnt_in;
      zero_ff    <= zero_in;
      heading_ff <= heading_in;
   end

   // ---------------- heading error and history ----------------
   assign bearing = zero_ff ? '0 : z_ff;
   assign e0      = $signed(bearing - heading_ff);

   always_comb begin
      e0_in    = e0_ff;
      d1_in    = d1_ff;
      d2_in    = d2_ff;
      last_in  = last_ff;
      prior_in = prior_ff;
      if (cmd.err) begin
         e0_in    = e0;
         d1_in    = hps_pkg::DIFF_W'(e0) - hps_pkg::DIFF_W'(last_ff);
         d2_in    = hps_pkg::DIFF_W'(e0) - (hps_pkg::DIFF_W'(last_ff) <<< 1)
                  + hps_pkg::DIFF_W'(prior_ff);
         last_in  = e0;
         prior_in = last_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_ff  <= '0;
         prior_ff <= '0;
      end else begin
         last_ff  <= last_in;
         prior_ff <= prior_in;
      end
   end

   always_ff @(posedge clock) begin
      e0_ff <= e0_in;
      d1_ff <= d1_in;
      d2_ff <= d2_in;
   end

   // ---------------- shared multiplier and accumulator ----------------
   always_comb begin
      case (cmd.mul_sel)
         hps_pkg::MUL_P: begin
            mul_a = $signed({1'b0, kp_ff});
            mul_b = d1_ff;
         end
         hps_pkg::MUL_I: begin
            mul_a = $signed({1'b0, ki_ff});
            mul_b = hps_pkg::DIFF_W'(e0_ff);
         end
         hps_pkg::MUL_D: begin
            mul_a = $signed({1'b0, kd_ff});
            mul_b = d2_ff;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
      prod_in = mul_a * mul_b;
   end

   always_comb begin
      case (cmd.acc_op)
         hps_pkg::ACC_LOAD: acc_in = hps_pkg::ACC_W'(prod_ff);
         hps_pkg::ACC_ADD:  acc_in = acc_ff + hps_pkg::ACC_W'(prod_ff);
         default:           acc_in = acc_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
   end

   // ---------------- shift, clamp and result register ----------------
   assign shifted = acc_ff >>> hps_pkg::FRAC_BITS;
   assign lim_pos = hps_pkg::ACC_W'($signed({1'b0, limit_ff}));
   assign lim_neg = -lim_pos;

   always_comb begin
      if (shifted > lim_pos) begin
         sat  = lim_pos;
         clip = 1'b1;
      end else if (shifted < lim_neg) begin
         sat  = lim_neg;
         clip = 1'b1;
      end else begin
         sat  = shifted;
         clip = 1'b0;
      end
      steer_in   = cmd.fin ? hps_pkg::ANGLE_W'(sat) : steer_ff;
      clamped_in = cmd.fin ? clip : clamped_ff;
   end

   always_ff @(posedge clock) begin
      steer_ff   <= steer_in;
      clamped_ff <= clamped_in;
   end

   assign rsp_steer_increment = steer_ff;
   assign rsp_clamped         = clamped_ff;

endmodule

@@ design/hps_ctrl.sv @@
// Controller: sequences load, CORDIC steps, PID multiplies and the result handshake.
module hps_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   input  hps_pkg::dp_status_type status,
   output hps_pkg::ctrl_cmd_type  cmd
);

   hps_pkg::state_type state_ff, state_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               out_free;

   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= hps_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in    = state_ff;
      cmd         = '0;
      cmd.mul_sel = hps_pkg::MUL_P;
      cmd.acc_op  = hps_pkg::ACC_HOLD;
      req_stall   = 1'b1;
      case (state_ff)
         hps_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = hps_pkg::ST_CORDIC;
            end
         end
         hps_pkg::ST_CORDIC: begin
            cmd.step = 1'b1;
            if (status.cordic_last) begin
               state_in = hps_pkg::ST_ERROR;
            end
         end
         hps_pkg::ST_ERROR: begin
            cmd.err  = 1'b1;
            state_in = hps_pkg::ST_MUL_P;
         end
         hps_pkg::ST_MUL_P: begin
            cmd.mul_sel = hps_pkg::MUL_P;
            state_in    = hps_pkg::ST_MUL_I;
         end
         hps_pkg::ST_MUL_I: begin
            cmd.mul_sel = hps_pkg::MUL_I;
            cmd.acc_op  = hps_pkg::ACC_LOAD;
            state_in    = hps_pkg::ST_MUL_D;
         end
         hps_pkg::ST_MUL_D: begin
            cmd.mul_sel = hps_pkg::MUL_D;
            cmd.acc_op  = hps_pkg::ACC_ADD;
            state_in    = hps_pkg::ST_ACC;
         end
         hps_pkg::ST_ACC: begin
            cmd.acc_op = hps_pkg::ACC_ADD;
            state_in   = hps_pkg::ST_DONE;
         end
         hps_pkg::ST_DONE: begin
            // hold until the result register can take the new value
            if (out_free) begin
               cmd.fin  = 1'b1;
               state_in = hps_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = hps_pkg::ST_IDLE;
         end
      endcase
      rsp_valid_in = cmd.fin || (rsp_valid_ff && rsp_stall);
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

@@ design/heading_pid_steering_unit.sv @@
// Top level of the heading PID steering unit: controller plus datapath.
// A new request is taken only after the previous result is in the response register;
// each request runs the 16-step CORDIC loop (one step per cycle), the error update,
// the three shared-multiplier products, the accumulate and the clamp.
// Reset: synchronous, active high; gains and limit return to defaults, error history to zero.
module heading_pid_steering_unit (
   input  logic                                  clock,
   input  logic                                  reset,
   // request channel
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic signed [hps_pkg::COORD_BITS-1:0] req_target_x,
   input  logic signed [hps_pkg::COORD_BITS-1:0] req_target_y,
   input  logic signed [hps_pkg::COORD_BITS-1:0] req_position_x,
   input  logic signed [hps_pkg::COORD_BITS-1:0] req_position_y,
   input  logic signed [hps_pkg::ANGLE_W-1:0]    req_heading,
   // response channel
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic signed [hps_pkg::ANGLE_W-1:0]    rsp_steer_increment,
   output logic                                  rsp_clamped,
   // configuration write port
   input  logic                                  csr_wr_en,
   input  logic [hps_pkg::CSR_IDX_W-1:0]         csr_index,
   input  logic [hps_pkg::CSR_W-1:0]             csr_wdata
);

   // Commands flow from the controller into the datapath; the only status
   // coming back is the end of the CORDIC iteration count.
   hps_pkg::ctrl_cmd_type  cmd;
   hps_pkg::dp_status_type status;

   // The controller owns both handshakes. A request transaction is taken only
   // in the idle state; the response register is separate, so a finished
   // result may wait on rsp_stall while the next request is already running.
   hps_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // The datapath captures the request on load, runs the vectoring CORDIC to
   // find the bearing, wraps the heading error, advances the two-deep error
   // history and forms the incremental PID sum on one shared multiplier.
   // The shifted sum is clamped to the limit and held in the result register.
   hps_datapath u_datapath (
      .clock               (clock),
      .reset               (reset),
      .req_target_x        (req_target_x),
      .req_target_y        (req_target_y),
      .req_position_x      (req_position_x),
      .req_position_y      (req_position_y),
      .req_heading         (req_heading),
      .csr_wr_en           (csr_wr_en),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata),
      .cmd                 (cmd),
      .status              (status),
      .rsp_steer_increment (rsp_steer_increment),
      .rsp_clamped         (rsp_clamped)
   );

endmodule

@@ design/hps_checker.sv @@
// Port-level checker for the steering unit and its bind to the top level.
`include "heading_pid_steering_unit_assert.svh"

module hps_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_valid,
   input logic                               req_stall,
   input logic                               rsp_valid,
   input logic                               rsp_stall,
   input logic signed [hps_pkg::ANGLE_W-1:0] rsp_steer_increment,
   input logic                               rsp_clamped
);

   // a stalled response holds its payload
   `HPS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_steer_increment) && $stable(rsp_clamped))

   // the unit is busy right after taking a request
   `HPS_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && !req_stall, req_stall)

   // a new result never shows up in the cycle after a request is taken
   `HPS_ASSERT_NEXT(a_no_early_rsp, clock, reset, req_valid && !req_stall, !$rose(rsp_valid))

   // the clamp limit is at most 15 bits, so the most negative code never appears
   `HPS_ASSERT_SAME(a_steer_range, clock, reset, rsp_valid, rsp_steer_increment != 16'h8000)

endmodule

bind heading_pid_steering_unit hps_checker u_hps_checker (.*);

@@ dv/heading_pid_steering_unit_tb.sv @@
// Self-checking testbench for the heading PID steering unit.
module heading_pid_steering_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic signed [hps_pkg::COORD_BITS-1:0] tx;
      logic signed [hps_pkg::COORD_BITS-1:0] ty;
      logic signed [hps_pkg::COORD_BITS-1:0] px;
      logic signed [hps_pkg::COORD_BITS-1:0] py;
      logic signed [hps_pkg::ANGLE_W-1:0]    hd;
   } nav_sample_type;

   typedef struct packed {
      logic signed [hps_pkg::ANGLE_W-1:0] steer;
      logic                               clamped;
   } steer_result_type;

   // Scoreboard: keeps its own copy of the gains, the limit and the error
   // history, predicts the steering change of every accepted request and
   // compares responses in order.
   class steer_scoreboard;
      logic [hps_pkg::GAIN_W-1:0]         kp;
      logic [hps_pkg::GAIN_W-1:0]         ki;
      logic [hps_pkg::GAIN_W-1:0]         kd;
      logic [hps_pkg::LIMIT_W-1:0]        limit;
      logic signed [hps_pkg::ANGLE_W-1:0] last_err;
      logic signed [hps_pkg::ANGLE_W-1:0] prior_err;
      int                                 atan_units[hps_pkg::CORDIC_STEPS];
      steer_result_type                   steer_expected[$];
      int                                 requests;
      int                                 responses;
      int                                 clamp_hits;
      int                                 errors;
      int                                 shown;

      function new();
         real pi;
         pi = 3.14159265358979;
         // atan(2^-i) in binary-angle units, rounded to nearest
         for (int i = 0; i < hps_pkg::CORDIC_STEPS; i++)
            atan_units[i] = $rtoi($atan(2.0 ** (-i)) * 32768.0 / pi + 0.5);
         kp = hps_pkg::KP_RESET;
         ki = '0;
         kd = '0;
         limit = hps_pkg::LIMIT_RESET;
         last_err = '0;
         prior_err = '0;
         requests = 0;
         responses = 0;
         clamp_hits = 0;
         errors = 0;
         shown = 0;
      endfunction

      function void write_reg(hps_pkg::csr_index_type idx, logic [hps_pkg::CSR_W-1:0] data);
         case (idx)
            hps_pkg::CSR_KP:    kp = data[hps_pkg::GAIN_W-1:0];
            hps_pkg::CSR_KI:    ki = data[hps_pkg::GAIN_W-1:0];
            hps_pkg::CSR_KD:    kd = data[hps_pkg::GAIN_W-1:0];
            hps_pkg::CSR_LIMIT: limit = data[hps_pkg::LIMIT_W-1:0];
            default: ;
         endcase
      endfunction

      // Vectoring CORDIC on the exact difference vector; left half plane is
      // pre-rotated by a quarter turn so the iterations converge.
      function logic [hps_pkg::ANGLE_W-1:0] bearing(longint x, longint y);
         logic [hps_pkg::ANGLE_W-1:0] z;
         longint t, xs, ys;
         z = '0;
         if (x == 0 && y == 0)
            return '0;
         if (x < 0) begin
            if (y >= 0) begin
               t = x; x = y; y = -t;
               z = hps_pkg::QUARTER_TURN;
            end else begin
               t = x; x = -y; y = t;
               z = hps_pkg::NEG_QUARTER_TURN;
            end
         end
         for (int i = 0; i < hps_pkg::CORDIC_STEPS; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (y >= 0) begin
               x = x + ys;
               y = y - xs;
               z = z + hps_pkg::ANGLE_W'(atan_units[i]);
            end else begin
               x = x - ys;
               y = y + xs;
               z = z - hps_pkg::ANGLE_W'(atan_units[i]);
            end
         end
         return z;
      endfunction

      function void log_sample(nav_sample_type s);
         longint dx, dy, e0, e1, e2, acc, u, lim;
         logic [hps_pkg::ANGLE_W-1:0] heading_err;
         steer_result_type r;
         dx = longint'($signed(s.tx)) - longint'($signed(s.px));
         dy = longint'($signed(s.ty)) - longint'($signed(s.py));
         heading_err = bearing(dx, dy) - hps_pkg::ANGLE_W'(s.hd);
         e0 = longint'($signed(heading_err));
         e1 = longint'(last_err);
         e2 = longint'(prior_err);
         acc = longint'(kp) * (e0 - e1) + longint'(ki) * e0
             + longint'(kd) * (e0 - 2 * e1 + e2);
         u = acc >>> hps_pkg::FRAC_BITS;
         lim = longint'(limit);
         r.clamped = 1'b0;
         if (u > lim) begin
            u = lim;
            r.clamped = 1'b1;
         end else if (u < -lim) begin
            u = -lim;
            r.clamped = 1'b1;
         end
         r.steer = u[hps_pkg::ANGLE_W-1:0];
         prior_err = last_err;
         last_err = heading_err;
         steer_expected.push_back(r);
         requests++;
      endfunction

      function void check_steer(logic signed [hps_pkg::ANGLE_W-1:0] steer, logic clamped);
         steer_result_type want;
         responses++;
         if (clamped)
            clamp_hits++;
         if (steer_expected.size() == 0) begin
            errors++;
            if (shown < 10) begin
               shown++;
               $display("unexpected response: steer=%0d clamped=%0b", steer, clamped);
            end
            return;
         end
         want = steer_expected.pop_front();
         if (want.steer !== steer || want.clamped !== clamped) begin
            errors++;
            if (shown < 10) begin
               shown++;
               $display("response %0d mismatch: expected steer=%0d clamped=%0b,",
                        responses, want.steer, want.clamped);
               $display("   got steer=%0d clamped=%0b", steer, clamped);
            end
         end
      endfunction

      function int pending();
         return steer_expected.size();
      endfunction
   endclass

   logic                                  clock;
   logic                                  reset;
   logic                                  req_valid;
   logic                                  req_stall;
   logic signed [hps_pkg::COORD_BITS-1:0] req_target_x;
   logic signed [hps_pkg::COORD_BITS-1:0] req_target_y;
   logic signed [hps_pkg::COORD_BITS-1:0] req_position_x;
   logic signed [hps_pkg::COORD_BITS-1:0] req_position_y;
   logic signed [hps_pkg::ANGLE_W-1:0]    req_heading;
   logic                                  rsp_valid;
   logic                                  rsp_stall;
   logic signed [hps_pkg::ANGLE_W-1:0]    rsp_steer_increment;
   logic                                  rsp_clamped;
   logic                                  csr_wr_en;
   logic [hps_pkg::CSR_IDX_W-1:0]         csr_index;
   logic [hps_pkg::CSR_W-1:0]             csr_wdata;

   steer_scoreboard sb;
   int              send_idle_pct;
   int              rsp_idle_pct;
   int              hold_left;
   int              settings_applied;

   localparam logic signed [hps_pkg::COORD_BITS-1:0] C_MAX =
      {1'b0, {(hps_pkg::COORD_BITS-1){1'b1}}};
   localparam logic signed [hps_pkg::COORD_BITS-1:0] C_MIN =
      {1'b1, {(hps_pkg::COORD_BITS-1){1'b0}}};

   heading_pid_steering_unit dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_target_x        (req_target_x),
      .req_target_y        (req_target_y),
      .req_position_x      (req_position_x),
      .req_position_y      (req_position_y),
      .req_heading         (req_heading),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_steer_increment (rsp_steer_increment),
      .rsp_clamped         (rsp_clamped),
      .csr_wr_en           (csr_wr_en),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata)
   );

   // 12 ns clock
   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Hard stop in case the block hangs or never drains.
   initial begin
      #5_000_000;
      $display("Some tests failed");
      $finish;
   end

   // Response-side back-pressure: a long hold-off when requested, otherwise
   // a random stall at the current rate. Change only at the falling edge.
   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_left > 0) begin
            rsp_stall <= 1'b1;
            hold_left--;
         end else begin
            rsp_stall <= ($urandom_range(99) < rsp_idle_pct);
         end
      end
   end

   // Bus monitor: sample every handshake at the rising edge, before the
   // block's own updates land, and feed the scoreboard.
   always @(posedge clock) begin : watch_bus
      nav_sample_type seen;
      if (!reset) begin
         if (csr_wr_en)
            sb.write_reg(hps_pkg::csr_index_type'(csr_index), csr_wdata);
         if (req_valid && !req_stall) begin
            seen.tx = req_target_x;
            seen.ty = req_target_y;
            seen.px = req_position_x;
            seen.py = req_position_y;
            seen.hd = req_heading;
            sb.log_sample(seen);
         end
         if (rsp_valid && !rsp_stall)
            sb.check_steer(rsp_steer_increment, rsp_clamped);
      end
   end

   function automatic nav_sample_type make_sample(
      logic signed [hps_pkg::COORD_BITS-1:0] tx, logic signed [hps_pkg::COORD_BITS-1:0] ty,
      logic signed [hps_pkg::COORD_BITS-1:0] px, logic signed [hps_pkg::COORD_BITS-1:0] py,
      logic signed [hps_pkg::ANGLE_W-1:0] hd);
      nav_sample_type s;
      s.tx = tx;
      s.ty = ty;
      s.px = px;
      s.py = py;
      s.hd = hd;
      return s;
   endfunction

   // Geometric gap length at the given per-cycle idle rate, capped.
   function automatic int draw_gap(int pct);
      int gap;
      gap = 0;
      while (gap < 20 && $urandom_range(99) < pct)
         gap++;
      return gap;
   endfunction

   function automatic logic [hps_pkg::GAIN_W-1:0] pick_gain();
      case ($urandom_range(6))
         0:       return '0;
         1:       return '1;
         2, 3:    return hps_pkg::GAIN_W'($urandom_range(0, 4095));
         4:       return hps_pkg::GAIN_W'($urandom_range(0, 16383));
         default: return hps_pkg::GAIN_W'($urandom_range(0, 65535));
      endcase
   endfunction

   // Limit write data; the top bit of the word is noise the block must drop.
   function automatic logic [hps_pkg::CSR_W-1:0] pick_limit();
      logic [hps_pkg::CSR_W-1:0] d;
      case ($urandom_range(6))
         0:       d = '0;
         1:       d = hps_pkg::CSR_W'(16384);
         2:       d = '1;
         default: d = hps_pkg::CSR_W'($urandom_range(1, 16384));
      endcase
      d[hps_pkg::CSR_W-1] = 1'($urandom_range(1));
      return d;
   endfunction

   // Random geometry: mostly nearby targets with a heading close to the
   // bearing so the PID terms stay in range, plus wide vectors, axis and
   // zero vectors, and headings near the opposite direction for wrap.
   function automatic nav_sample_type random_sample();
      nav_sample_type s;
      int             reach;
      int             kind;
      longint         dx, dy;
      logic [hps_pkg::ANGLE_W-1:0] b;
      s.px = hps_pkg::COORD_BITS'($urandom());
      s.py = hps_pkg::COORD_BITS'($urandom());
      kind = $urandom_range(19);
      if (kind < 7) begin
         s.tx = hps_pkg::COORD_BITS'($urandom());
         s.ty = hps_pkg::COORD_BITS'($urandom());
      end else if (kind < 17) begin
         reach = 1 << $urandom_range(0, 18);
         s.tx = s.px + hps_pkg::COORD_BITS'(int'($urandom_range(0, 2 * reach)) - reach);
         s.ty = s.py + hps_pkg::COORD_BITS'(int'($urandom_range(0, 2 * reach)) - reach);
      end else if (kind == 17) begin
         s.tx = s.px;
         s.ty = s.py;
      end else begin
         s.tx = (kind == 18) ? s.px : hps_pkg::COORD_BITS'($urandom());
         s.ty = (kind == 18) ? hps_pkg::COORD_BITS'($urandom()) : s.py;
      end
      dx = longint'($signed(s.tx)) - longint'($signed(s.px));
      dy = longint'($signed(s.ty)) - longint'($signed(s.py));
      b = sb.bearing(dx, dy);
      case ($urandom_range(5))
         0, 1:    s.hd = hps_pkg::ANGLE_W'($urandom());
         2:       s.hd = b + 16'h8000 + hps_pkg::ANGLE_W'(int'($urandom_range(0, 512)) - 256);
         default: s.hd = b + hps_pkg::ANGLE_W'(int'($urandom_range(0, 2048)) - 1024);
      endcase
      return s;
   endfunction

   // Offer one request transaction after an optional gap; hold it until the
   // block takes it. Valid stays high on return so back-to-back items need
   // no extra assignment.
   task automatic send_sample(nav_sample_type s, int gap);
      repeat (gap) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
      @(negedge clock);
      req_valid      <= 1'b1;
      req_target_x   <= s.tx;
      req_target_y   <= s.ty;
      req_position_x <= s.px;
      req_position_y <= s.py;
      req_heading    <= s.hd;
      do @(posedge clock); while (req_stall);
   endtask

   // Drop valid and wait until every predicted response has come back.
   task automatic wait_drained();
      @(negedge clock);
      req_valid <= 1'b0;
      while (sb.pending() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_csr(hps_pkg::csr_index_type idx, logic [hps_pkg::CSR_W-1:0] data);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
   endtask

   // Program all four registers while the block is idle.
   task automatic set_config(logic [hps_pkg::GAIN_W-1:0] kp, logic [hps_pkg::GAIN_W-1:0] ki,
                             logic [hps_pkg::GAIN_W-1:0] kd, logic [hps_pkg::CSR_W-1:0] lim);
      write_csr(hps_pkg::CSR_KP, kp);
      write_csr(hps_pkg::CSR_KI, ki);
      write_csr(hps_pkg::CSR_KD, kd);
      write_csr(hps_pkg::CSR_LIMIT, lim);
      @(negedge clock);
      csr_wr_en <= 1'b0;
      @(posedge clock);
      settings_applied++;
   endtask

   initial begin
      int failures;
      sb = new();
      send_idle_pct = 0;
      rsp_idle_pct = 0;
      hold_left = 0;
      settings_applied = 1;
      reset = 1'b1;
      req_valid = 1'b0;
      req_target_x = '0;
      req_target_y = '0;
      req_position_x = '0;
      req_position_y = '0;
      req_heading = '0;
      csr_wr_en = 1'b0;
      csr_index = hps_pkg::CSR_KP;
      csr_wdata = '0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed, reset gains: zero vector, coordinate extremes, second and third
      // quadrants, every axis, and headings that force the error to wrap.
      send_sample(make_sample('0, '0, '0, '0, '0), 0);
      send_sample(make_sample(C_MAX, '0, C_MIN, '0, '0), 0);
      send_sample(make_sample(C_MIN, C_MAX, C_MAX, C_MIN, 16'sh8000), 0);
      send_sample(make_sample(C_MIN, C_MIN, C_MAX, C_MAX, 16'sh7FFF), 0);
      send_sample(make_sample(-24'sd100, 24'sd5, '0, 24'sd5, 16'sd16), 0);
      send_sample(make_sample(24'sd7, -24'sd300, 24'sd7, '0, '0), 0);
      send_sample(make_sample(24'sd7, 24'sd300, 24'sd7, '0, '0), 0);
      send_sample(make_sample(-24'sd1000, 24'sd1, '0, '0, -16'sd32668), 0);
      send_sample(make_sample(-24'sd1000, -24'sd1, '0, '0, 16'sd32700), 0);
      wait_drained();

      // Maximum gains and a limit word of all ones (masked to 15 bits, 32767).
      set_config('1, '1, '1, '1);
      send_sample(make_sample(24'sd1, '0, '0, '0, 16'sh8000), 0);
      send_sample(make_sample(24'sd1, '0, '0, '0, 16'sh7FFF), 0);
      send_sample(make_sample(24'sd1, '0, '0, '0, 16'sh8000), 0);
      send_sample(make_sample(24'sd1, '0, '0, '0, '0), 0);
      wait_drained();

      // Zero limit: any nonzero output collapses to zero with the flag set.
      set_config(16'd4096, '0, '0, '0);
      send_sample(make_sample(24'sd50, 24'sd50, '0, '0, '0), 0);
      send_sample(make_sample(24'sd50, -24'sd50, '0, '0, '0), 0);
      send_sample(make_sample(24'sd50, -24'sd50, '0, '0, -16'sd8192), 0);
      wait_drained();

      // Moderate gains on a limit of 16384.
      set_config(16'd4096, 16'd1024, 16'd2048, 16'd16384);
      send_sample(make_sample(24'sd900, 24'sd100, '0, '0, 16'sd300), 0);
      send_sample(make_sample(24'sd900, 24'sd400, '0, '0, -16'sd300), 0);
      send_sample(make_sample(-24'sd900, 24'sd100, '0, '0, 16'sd30000), 0);
      send_sample(make_sample(-24'sd900, -24'sd100, '0, '0, -16'sd30000), 0);
      wait_drained();

      // Random phases: new gains and limit each time, idling pattern
      // rotating from sender-light to receiver-light to none.
      for (int ph = 0; ph < 12; ph++) begin
         wait_drained();
         set_config(pick_gain(), pick_gain(), pick_gain(), pick_limit());
         case (ph / 4)
            0: begin
               send_idle_pct = 30;
               rsp_idle_pct = 67;
            end
            1: begin
               send_idle_pct = 67;
               rsp_idle_pct = 30;
            end
            default: begin
               send_idle_pct = 0;
               rsp_idle_pct = 0;
            end
         endcase
         // Long receiver hold-off while the sender keeps pushing: fills
         // the block and backs up the request side.
         if (ph == 8)
            hold_left = 400;
         for (int n = 0; n < 50; n++) begin
            // Sender pause until the block has fully drained.
            if (ph == 4 && n == 25)
               wait_drained();
            send_sample(random_sample(), draw_gap(send_idle_pct));
         end
      end

      wait_drained();
      repeat (40) @(posedge clock);

      failures = sb.errors + sb.pending();
      $display("Run covered %0d requests and %0d responses (%0d clamped)",
               sb.requests, sb.responses, sb.clamp_hits);
      $display("under %0d gain/limit settings; mismatched or unexpected responses: %0d",
               settings_applied, sb.errors);
      if (failures == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
